### rtl/fpenc_pkg.sv
// Shared types, line constants and checksum helper for the FPort frame encoder.
package fpenc_pkg;

    localparam logic [7:0] FRAME_MARK = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] FLIP_MASK  = 8'h20;

    localparam logic [1:0] CFG_FLAGS = 2'd0;
    localparam logic [1:0] CFG_RSSI  = 2'd1;
    localparam logic [1:0] CFG_TYPE  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] ftype;
        logic [7:0] flags;
        logic [7:0] rssi;
        logic [7:0] check;
    } desc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LEN,
        ST_TYPE,
        ST_DATA,
        ST_FLAGS,
        ST_RSSI,
        ST_CHECK,
        ST_END
    } back_state_t;

    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

### rtl/fpenc_front.sv
// Front part: holds configuration, tracks frame position and checksum, builds requests.
module fpenc_front #(
    parameter int PAYLOAD_BYTES = 22
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          payload_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output fpenc_pkg::desc_t    desc
);
    import fpenc_pkg::*;

    localparam logic [7:0] LEN_BYTE = 8'((PAYLOAD_BYTES + 3) % 256);
    localparam logic [8:0] LAST_POS = 9'(PAYLOAD_BYTES);

    logic [7:0] flags_reg;
    logic [7:0] rssi_reg;
    logic [7:0] ftype_reg;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] s_base;
    logic [7:0] s_data;
    logic [7:0] s_tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 8'h00;
            rssi_reg  <= 8'h0F;
            ftype_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FLAGS)
            begin
                flags_reg <= cfg_data;
            end
            else if (cfg_index == CFG_RSSI)
            begin
                rssi_reg <= cfg_data;
            end
            else if (cfg_index == CFG_TYPE)
            begin
                ftype_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        desc.data  = payload_byte;
        desc.first = (pos_reg == 8'd0);
        desc.last  = (({1'b0, pos_reg} + 9'd1) >= LAST_POS);
        desc.ftype = ftype_reg;
        desc.flags = flags_reg;
        desc.rssi  = rssi_reg;
        s_base     = desc.first ? eac_add(LEN_BYTE, ftype_reg) : sum_reg;
        s_data     = eac_add(s_base, payload_byte);
        s_tail     = eac_add(eac_add(s_data, flags_reg), rssi_reg);
        desc.check = ~s_tail;
        if (desc.last)
        begin
            pos_next = 8'd0;
            sum_next = 8'd0;
        end
        else
        begin
            pos_next = pos_reg + 8'd1;
            sum_next = s_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
            sum_reg <= 8'd0;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // hold position within the payload
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} < LAST_POS))
        else $error("frame position out of range");
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        take && desc.last |=> pos_reg == 8'd0)
        else $error("position not cleared after last payload byte");

endmodule

### rtl/fpenc_queue.sv
// Short request queue between the front and back parts.
module fpenc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count overflow");

endmodule

### rtl/fpenc_back.sv
// Back part: walks each request through its frame slots and emits stuffed line bytes.
module fpenc_back #(
    parameter int PAYLOAD_BYTES = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  fpenc_pkg::desc_t q_desc,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       line_byte,
    output logic             last_of_run,
    output logic             frame_end
);
    import fpenc_pkg::*;

    localparam logic [7:0] LEN_BYTE = 8'((PAYLOAD_BYTES + 3) % 256);

    back_state_t state_reg;
    back_state_t state_next;
    desc_t       desc_reg;
    desc_t       desc_next;
    logic        esc_reg;
    logic        esc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        out_end_reg;
    logic        out_end_next;
    logic        emit_ok;
    logic        stuffable;
    logic        special;
    logic        finish;
    logic [7:0]  cur_byte;

    assign empty       = !out_valid_reg;
    assign line_byte   = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign frame_end   = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        desc_next      = desc_reg;
        esc_next       = esc_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        q_pop          = 1'b0;
        finish         = 1'b0;
        emit_ok        = !out_valid_reg || pop;
        stuffable      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cur_byte  = FRAME_MARK;
                stuffable = 1'b0;
            end
            ST_START:
            begin
                cur_byte  = FRAME_MARK;
                stuffable = 1'b0;
            end
            ST_LEN:   cur_byte = LEN_BYTE;
            ST_TYPE:  cur_byte = desc_reg.ftype;
            ST_DATA:  cur_byte = desc_reg.data;
            ST_FLAGS: cur_byte = desc_reg.flags;
            ST_RSSI:  cur_byte = desc_reg.rssi;
            ST_CHECK: cur_byte = desc_reg.check;
            ST_END:
            begin
                cur_byte  = FRAME_MARK;
                stuffable = 1'b0;
            end
            default:
            begin
                cur_byte  = FRAME_MARK;
                stuffable = 1'b0;
            end
        endcase
        special = (cur_byte == FRAME_MARK) || (cur_byte == ESC_BYTE);

        if (state_reg == ST_IDLE)
        begin
            if (!q_empty)
            begin
                q_pop      = 1'b1;
                desc_next  = q_desc;
                state_next = q_desc.first ? ST_START : ST_DATA;
            end
        end
        else if (emit_ok)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_end_next   = 1'b0;
            if (stuffable && special && !esc_reg)
            begin
                out_byte_next = ESC_BYTE;
                esc_next      = 1'b1;
            end
            else
            begin
                out_byte_next = esc_reg ? (cur_byte ^ FLIP_MASK) : cur_byte;
                esc_next      = 1'b0;
                unique case (state_reg)
                    ST_START: state_next = ST_LEN;
                    ST_LEN:   state_next = ST_TYPE;
                    ST_TYPE:  state_next = ST_DATA;
                    ST_DATA:
                    begin
                        if (desc_reg.last)
                        begin
                            state_next = ST_FLAGS;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    ST_FLAGS: state_next = ST_RSSI;
                    ST_RSSI:  state_next = ST_CHECK;
                    ST_CHECK: state_next = ST_END;
                    ST_END:
                    begin
                        out_end_next = 1'b1;
                        finish       = 1'b1;
                    end
                    default:  state_next = ST_IDLE;
                endcase
                if (finish)
                begin
                    out_last_next = 1'b1;
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        desc_next  = q_desc;
                        state_next = q_desc.first ? ST_START : ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        end
    end

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_last_reg)
        else $error("end byte not marked as last of request");
    a_idle_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !esc_reg)
        else $error("escape pending while idle");
    a_escape_follows: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg && emit_ok |=> out_valid_reg && !out_last_reg || out_valid_reg)
        else $error("flipped byte not emitted after escape");

endmodule

### rtl/fport_control_frame_encoder.sv
// Top level of the FPort control frame encoder.
//
// Usage: push one raw payload byte per request on payload_byte while full is
// low. The first byte of a frame is preceded by start, length and type bytes;
// the last is followed by flags, RSSI, checksum and end byte. Bytes 0x7E and
// 0x7D between start and end go out as 0x7D and the byte XOR 0x20.
// Line bytes appear on line_byte while empty is low and are taken with pop;
// last_of_run marks the final byte of a request, frame_end the closing byte.
// Configuration: cfg_index 0 flags, 1 RSSI, 2 frame type; cfg_ready is
// always high, write only while no frame bytes are in flight.
// A pushed request is written to the queue, then loaded into the back end's
// descriptor register, with a separate load step when the back end is idle,
// and sent through the output register. The back end emits one line byte per
// cycle while the receiver pops. A four-entry request queue lets the input
// run ahead.
// Reset clears the queue, the frame position, the checksum and the output
// valid flag; flags reset to 0x00, RSSI to 0x0F, type to 0x00. When the
// receiver stalls the output byte holds and the queue fills, then full rises.
module fport_control_frame_encoder #(
    parameter int PAYLOAD_BYTES = 22,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] payload_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] line_byte,
    output logic       last_of_run,
    output logic       frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import fpenc_pkg::*;

    localparam int DW = $bits(desc_t);

    logic    take;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    desc_t   front_desc;
    desc_t   q_desc;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign take      = push && !q_full;

    fpenc_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .payload_byte (payload_byte),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .desc         (front_desc)
    );

    fpenc_queue #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_desc),
        .rd_en   (q_pop),
        .rd_data (q_desc),
        .full    (q_full),
        .empty   (q_empty)
    );

    fpenc_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_desc      (q_desc),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .line_byte   (line_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

### tb/tb_fport_control_frame_encoder.sv
// Self-checking testbench for the FPort control frame encoder: framing, stuffing, checksum.
module tb_fport_control_frame_encoder;
    import fpenc_pkg::*;

    localparam int PAYLOAD_BYTES = 22;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 88;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } line_word_t;

    class frame_scoreboard;
        line_word_t expected[$];
        logic [7:0] flags_reg;
        logic [7:0] rssi_reg;
        logic [7:0] type_reg;
        logic [7:0] position;
        logic [7:0] sum;
        int errors;
        int requests;
        int bytes_seen;
        int frames;

        function new();
            flags_reg = 8'h00;
            rssi_reg = 8'h0F;
            type_reg = 8'h00;
            position = 8'h00;
            sum = 8'h00;
            errors = 0;
            requests = 0;
            bytes_seen = 0;
            frames = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void write_register(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_FLAGS: flags_reg = val;
                CFG_RSSI:  rssi_reg = val;
                CFG_TYPE:  type_reg = val;
                default:   ;
            endcase
        endfunction

        function void accumulate(logic [7:0] b);
            logic [8:0] t;
            t = {1'b0, sum} + {1'b0, b};
            sum = t[7:0] + {7'd0, t[8]};
        endfunction

        function void emit_raw(logic [7:0] b, logic fend);
            line_word_t w;
            w.data = b;
            w.last = 1'b0;
            w.fend = fend;
            expected.push_back(w);
        endfunction

        function void emit_stuffed(logic [7:0] b);
            if (b == FRAME_MARK || b == ESC_BYTE) begin
                emit_raw(ESC_BYTE, 1'b0);
                emit_raw(b ^ FLIP_MASK, 1'b0);
            end
            else
                emit_raw(b, 1'b0);
        endfunction

        function void note_request(logic [7:0] b);
            logic [7:0] frame_len;
            frame_len = 8'(PAYLOAD_BYTES + 3);
            requests++;
            if (position == 8'd0) begin
                sum = 8'h00;
                emit_raw(FRAME_MARK, 1'b0);
                emit_stuffed(frame_len);
                accumulate(frame_len);
                emit_stuffed(type_reg);
                accumulate(type_reg);
            end
            emit_stuffed(b);
            accumulate(b);
            if (int'(position) + 1 >= PAYLOAD_BYTES) begin
                emit_stuffed(flags_reg);
                accumulate(flags_reg);
                emit_stuffed(rssi_reg);
                accumulate(rssi_reg);
                emit_stuffed(8'hFF - sum);
                emit_raw(FRAME_MARK, 1'b1);
                position = 8'h00;
                sum = 8'h00;
                frames++;
            end
            else
                position = position + 8'd1;
            expected[expected.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [7:0] data, logic last, logic fend);
            line_word_t exp_word;
            bytes_seen++;
            if (expected.size() == 0) begin
                $error("line byte 0x%02h arrived with no request pending", data);
                errors++;
                return;
            end
            exp_word = expected.pop_front();
            if (data !== exp_word.data) begin
                $error("line_byte: expected 0x%02h, got 0x%02h", exp_word.data, data);
                errors++;
            end
            if (last !== exp_word.last) begin
                $error("last_of_run: expected %0b, got %0b", exp_word.last, last);
                errors++;
            end
            if (fend !== exp_word.fend) begin
                $error("frame_end: expected %0b, got %0b", exp_word.fend, fend);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] payload_byte = 8'h00;
    logic       pop = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'h00;
    logic       full;
    logic       empty;
    logic [7:0] line_byte;
    logic       last_of_run;
    logic       frame_end;
    logic       cfg_ready;

    frame_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  cfg_writes = 0;

    fport_control_frame_encoder #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .empty        (empty),
        .pop          (pop),
        .line_byte    (line_byte),
        .last_of_run  (last_of_run),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(line_byte, last_of_run, frame_end);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles without progress", quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_payload();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return FRAME_MARK;
        else if (sel < 30)
            return ESC_BYTE;
        else if (sel < 35)
            return 8'h00;
        else if (sel < 40)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_request(logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        payload_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.note_request(b);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_request(pick_payload());
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, val);
        cfg_writes++;
    endtask

    task automatic reconfigure(logic [7:0] flags, logic [7:0] rssi, logic [7:0] ftype);
        pause_until_drained();
        cfg_write(CFG_FLAGS, flags);
        cfg_write(CFG_RSSI, rssi);
        cfg_write(CFG_TYPE, ftype);
        cfg_write(CFG_SPARE, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed_frame[PAYLOAD_BYTES];
        directed_frame = '{8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h5E,
                           8'h5D, 8'h20, 8'hAA, 8'h55, 8'h7E, 8'h7E, 8'h7D, 8'h7D,
                           8'h02, 8'h40, 8'h10, 8'h04, 8'h08, 8'h7D};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reconfigure(8'h7E, 8'h7D, 8'h7D);
        foreach (directed_frame[i])
            send_request(directed_frame[i]);

        reconfigure(8'hFF, 8'h00, 8'h7E);
        hold_req = 1'b1;
        send_random(PHASE_ITEMS);

        reconfigure(8'h00, 8'hFF, 8'hFF);
        tx_idle_pct = 79;
        send_random(PHASE_ITEMS / 2);
        pause_until_drained();
        send_random(PHASE_ITEMS / 2);

        reconfigure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        tx_idle_pct = 0;
        rx_stall_pct = 79;
        send_random(PHASE_ITEMS);

        reconfigure(8'h7D, 8'h7E, 8'h00);
        tx_idle_pct = 16;
        rx_stall_pct = 16;
        send_random(PHASE_ITEMS / 2);
        hold_req = 1'b1;
        send_random(PHASE_ITEMS / 2);

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Pushed %0d payload bytes closing %0d frames; checked %0d line bytes.",
                 sb.requests, sb.frames, sb.bytes_seen);
        $display("Made %0d register writes across five settings, with idle, stall and hold-off.",
                 cfg_writes);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
